// File: sv/sapq_pkg.sv
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and constants for the sorted shift-cell priority queue.
// ----------------------------------------------------------------------------
package sapq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 128;
   localparam int DATA_W              = 32;
   localparam int ENTRY_COUNT_W       = 8;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_PEEK   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]               op;
      logic signed [DATA_W-1:0] element_value;
      logic signed [DATA_W-1:0] priority_value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic                     top_valid;
      logic signed [DATA_W-1:0] top_element;
      logic signed [DATA_W-1:0] top_priority;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] element_value;
      logic signed [DATA_W-1:0] priority_value;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctl_type;

endpackage

// File: sv/sapq_cell.sv
// ----------------------------------------------------------------------------
// sapq_cell
// One slot of the sorted chain: holds, loads the new entry, or takes a
// neighbor's entry.
// ----------------------------------------------------------------------------
module sapq_cell (
   input  logic                   clock,
   input  sapq_pkg::cell_ctl_type ctl,
   input  sapq_pkg::entry_type    new_entry,
   input  sapq_pkg::entry_type    above_entry,
   input  sapq_pkg::entry_type    below_entry,
   input  logic                   occupied,
   input  logic                   keep_above,
   output logic                   keep,
   output sapq_pkg::entry_type    entry
);

   sapq_pkg::entry_type entry_ff;
   sapq_pkg::entry_type entry_in;

   assign keep  = occupied && (entry_ff.priority_value > new_entry.priority_value);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (!keep) begin
            entry_in = keep_above ? new_entry : above_entry;
         end
      end else if (ctl.remove) begin
         entry_in = below_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: sv/sorted_array_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_core
// Priority queue held as a chain of compare-and-shift cells, top at cell 0.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle; busy stays low. Every cell compares
// its priority with the incoming one and shifts in the same cycle, so the
// request's result appears on the rsp_ ports with rsp_strobe in the cycle
// after acceptance, for one cycle only; the receiver cannot stall it.
module sorted_array_priority_queue_core #(
   parameter int QUEUE_DEPTH = sapq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sapq_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output sapq_pkg::rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                   accept;
   logic                   is_full;
   logic                   is_empty;
   sapq_pkg::cell_ctl_type ctl;
   sapq_pkg::entry_type    new_entry;
   sapq_pkg::entry_type    cell_entry [QUEUE_DEPTH];
   logic                   cell_keep  [QUEUE_DEPTH];

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   strobe_ff;
   logic [1:0]             status_ff;
   logic [1:0]             status_in;
   logic [CNT_W+sapq_pkg::ENTRY_COUNT_W-1:0] count_ext;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign is_full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty  = (count_ff == '0);
   assign new_entry = '{element_value:  req_payload.element_value,
                        priority_value: req_payload.priority_value};

   always_comb begin
      ctl       = '0;
      count_in  = count_ff;
      status_in = sapq_pkg::STATUS_OK;
      if (accept) begin
         if (req_payload.op == sapq_pkg::OP_INSERT) begin
            if (is_full) begin
               status_in = sapq_pkg::STATUS_FULL;
            end else begin
               ctl.insert = 1'b1;
               count_in   = count_ff + CNT_W'(1);
            end
         end else if (req_payload.op == sapq_pkg::OP_REMOVE) begin
            if (is_empty) begin
               status_in = sapq_pkg::STATUS_EMPTY;
            end else begin
               ctl.remove = 1'b1;
               count_in   = count_ff - CNT_W'(1);
            end
         end
      end
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                occupied;
      logic                keep_above;
      sapq_pkg::entry_type above_entry;
      sapq_pkg::entry_type below_entry;

      assign occupied = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign keep_above  = 1'b1;
         assign above_entry = new_entry;
      end else begin : g_mid
         assign keep_above  = cell_keep[i-1];
         assign above_entry = cell_entry[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign below_entry = cell_entry[i];
      end else begin : g_inner
         assign below_entry = cell_entry[i+1];
      end

      sapq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .new_entry   (new_entry),
         .above_entry (above_entry),
         .below_entry (below_entry),
         .occupied    (occupied),
         .keep_above  (keep_above),
         .keep        (cell_keep[i]),
         .entry       (cell_entry[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         status_ff <= sapq_pkg::STATUS_OK;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= accept;
         status_ff <= status_in;
      end
   end

   assign count_ext = {{sapq_pkg::ENTRY_COUNT_W{1'b0}}, count_ff};

   always_comb begin
      rsp_payload.status      = status_ff;
      rsp_payload.top_valid   = !is_empty;
      rsp_payload.top_element = is_empty ? '0 : cell_entry[0].element_value;
      rsp_payload.top_priority = is_empty ? '0 : cell_entry[0].priority_value;
      rsp_payload.entry_count = count_ext[sapq_pkg::ENTRY_COUNT_W-1:0];
   end

   assign rsp_strobe = strobe_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count beyond depth");

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted request gave no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result without request");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.op == sapq_pkg::OP_INSERT && !is_full
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow count");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.op == sapq_pkg::OP_REMOVE && is_empty
      |=> rsp_payload.status == sapq_pkg::STATUS_EMPTY && count_ff == '0)
      else $error("remove on empty not flagged");

   a_sorted_top: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CNT_W'(2)
      |-> cell_entry[0].priority_value >= cell_entry[1].priority_value)
      else $error("top cells out of order");

endmodule
